>>> rtl/core/olpd_pkg.sv
package olpd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int ECOUNT_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_FRONT  = 2'd0,
        REQ_BACK   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    // per-cycle command broadcast to every cell, already qualified by accept
    typedef struct packed {
        logic front;
        logic back;
        logic del;
    } t_cell_ctrl;

endpackage

>>> rtl/core/olpd_cell.sv
module olpd_cell import olpd_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic signed [VALUE_W-1:0] i_key,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic signed [VALUE_W-1:0] i_next_value,
    input  logic                      i_hit,
    output logic                      o_hit,
    output logic signed [VALUE_W-1:0] o_value
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_used;
    logic                      w_tail;
    logic                      w_match;

    assign w_used  = CNT_W'(INDEX) < i_count;
    assign w_tail  = CNT_W'(INDEX) == i_count;
    assign w_match = w_used && (r_value == i_key);
    // the first match closes the gap, so it and every cell behind it pull from the right
    assign o_hit   = i_hit | w_match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.front) begin
            n_value = i_prev_value;
        end else if (i_ctrl.back && w_tail) begin
            n_value = i_key;
        end else if (i_ctrl.del && o_hit) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> rtl/core/ordered_list_push_delete.sv
// the result of a request is registered and offered in the cycle after its transaction
// throughput: one request per cycle while the output is not stalled; the key match
// ripples through the cell chain in that cycle and sets the clock period
// reset (synchronous, active low) empties the list and drops any pending result;
// entry values are not cleared
module ordered_list_push_delete import olpd_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [REQ_W-1:0]           i_req_type,
    input  logic signed [VALUE_W-1:0]  i_item_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [ECOUNT_W-1:0]        o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_status                   r_status;
    t_status                   n_status;
    logic                      w_accept;
    logic                      w_full;
    t_req                      w_req;
    t_cell_ctrl                w_ctrl;
    logic [31:0]               w_count32;
    logic signed [VALUE_W-1:0] w_value [DEPTH];
    logic                      w_hit   [DEPTH+1];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_full     = r_count == CNT_W'(DEPTH);
    assign w_req      = t_req'(i_req_type);

    always_comb begin
        w_ctrl = '0;
        if (w_accept) begin
            case (w_req)
                REQ_FRONT:  w_ctrl.front = ~w_full;
                REQ_BACK:   w_ctrl.back  = ~w_full;
                REQ_DELETE: w_ctrl.del   = 1'b1;
                default:    w_ctrl = '0;
            endcase
        end
    end

    assign w_hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VALUE_W-1:0] w_prev;
            logic signed [VALUE_W-1:0] w_next;
            if (g == 0) begin : g_head
                assign w_prev = i_item_value;
            end else begin : g_body
                assign w_prev = w_value[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_next = w_value[g];
            end else begin : g_mid
                assign w_next = w_value[g+1];
            end
            olpd_cell #(
                .DEPTH (DEPTH),
                .INDEX (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_count      (r_count),
                .i_key        (i_item_value),
                .i_prev_value (w_prev),
                .i_next_value (w_next),
                .i_hit        (w_hit[g]),
                .o_hit        (w_hit[g+1]),
                .o_value      (w_value[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid & i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_DONE;
            case (w_req)
                REQ_FRONT, REQ_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_DELETE: begin
                    if (w_hit[DEPTH]) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = ST_MISS;
                    end
                end
                default: n_status = ST_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // count only moves with a transaction, which waits until the result is taken
    assign w_count32     = 32'(r_count);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = w_count32[ECOUNT_W-1:0];

endmodule

>>> dv/ordered_list_push_delete_test.sv
module ordered_list_push_delete_test;
    import olpd_pkg::*;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam int PHASE_ITEMS = 460;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_req                      req;
        logic signed [VALUE_W-1:0] value;
    } list_request_t;

    typedef struct {
        t_status             status;
        logic [ECOUNT_W-1:0] count;
    } list_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [REQ_W-1:0]          i_req_type = REQ_NONE;
    logic signed [VALUE_W-1:0] i_item_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic [ECOUNT_W-1:0]       o_entry_count;

    list_request_t             pending_requests[$];
    list_result_t              expected_results[$];
    logic signed [VALUE_W-1:0] list_values[$];
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    bit                        long_hold = 1'b0;
    int                        accepted_total = 0;
    int                        error_count = 0;

    ordered_list_push_delete dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // apply one request to the list copy and return its status and count
    function automatic list_result_t apply_list_request(t_req req,
                                                        logic signed [VALUE_W-1:0] value);
        list_result_t res;
        int           hit;
        res.status = ST_DONE;
        hit = -1;
        case (req)
            REQ_FRONT, REQ_BACK: begin
                if (list_values.size() >= DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else if (req == REQ_FRONT) begin
                    list_values.push_front(value);
                end else begin
                    list_values.push_back(value);
                end
            end
            REQ_DELETE: begin
                for (int i = 0; i < list_values.size(); i++) begin
                    if (hit < 0 && list_values[i] == value) hit = i;
                end
                if (hit < 0) res.status = ST_MISS;
                else list_values.delete(hit);
            end
            default: ;
        endcase
        res.count = ECOUNT_W'(list_values.size());
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_request(t_req req, logic signed [VALUE_W-1:0] value);
        list_request_t r;
        r.req = req;
        r.value = value;
        pending_requests.push_back(r);
    endtask

    // mostly a small pool of keys so that deletes hit and duplicates build up
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] pool[8];
        pool = '{0, 1, -1, 7, 42, VALUE_MIN, VALUE_MAX, 32'sh5a5a_5a5a};
        case ($urandom_range(9))
            6: return $urandom;
            7: return VALUE_MIN;
            8: return VALUE_MAX;
            9: return $urandom_range(15);
            default: return pool[$urandom_range(7)];
        endcase
    endfunction

    // mode 0 fills, mode 1 drains, mode 2 mixes evenly
    function automatic t_req pick_req(int mode);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return REQ_NONE;
        case (mode)
            0: return (roll < 80) ? ((roll & 1) ? REQ_FRONT : REQ_BACK) : REQ_DELETE;
            1: return (roll < 75) ? REQ_DELETE : ((roll & 1) ? REQ_FRONT : REQ_BACK);
            default: return (roll < 36) ? REQ_FRONT : (roll < 68) ? REQ_BACK : REQ_DELETE;
        endcase
    endfunction

    // driver: a new transaction is offered only once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_requests.size() == 0 || $urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_req_type <= pending_requests[0].req;
                i_item_value <= pending_requests[0].value;
                void'(pending_requests.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result status %0d count %0d with none expected",
                                          o_status, o_entry_count));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_entry_count !== want.count)
                    report_mismatch($sformatf("entry count got %0d want %0d",
                                              o_entry_count, want.count));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(apply_list_request(t_req'(i_req_type), i_item_value));
            accepted_total++;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        while (accepted_total < 200) @(posedge i_clk);
        @(negedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        #400000;
        $display("ordered_list_push_delete regression: fail");
        $finish;
    end

    initial begin
        int mode;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, extremes, duplicates, full store, first-match delete
        queue_request(REQ_DELETE, 0);
        queue_request(REQ_NONE, VALUE_MAX);
        queue_request(REQ_FRONT, VALUE_MIN);
        queue_request(REQ_BACK, VALUE_MAX);
        queue_request(REQ_FRONT, 0);
        queue_request(REQ_BACK, -1);
        queue_request(REQ_FRONT, 5);
        queue_request(REQ_BACK, 5);
        for (int i = 0; i < 10; i++) queue_request(REQ_BACK, 100 + i);
        queue_request(REQ_FRONT, 77);
        queue_request(REQ_BACK, 78);
        queue_request(REQ_DELETE, 5);
        queue_request(REQ_DELETE, VALUE_MAX);
        queue_request(REQ_DELETE, 1234);
        queue_request(REQ_NONE, 0);
        queue_request(REQ_DELETE, VALUE_MIN);

        // sender pause until every expected result is back
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 9 : 0;
            mode = 2;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0) mode = $urandom_range(2);
                queue_request(pick_req(mode), pick_value());
            end
            while (pending_requests.size() != 0 || i_in_valid) @(posedge i_clk);
        end

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ordered_list_push_delete regression: pass");
        end else begin
            $display("ordered_list_push_delete regression: fail");
        end
        $finish;
    end

endmodule

>>> ordered_list_push_delete.f
rtl/core/olpd_pkg.sv
rtl/core/olpd_cell.sv
rtl/core/ordered_list_push_delete.sv
dv/ordered_list_push_delete_test.sv
